// ===== src/mwv_pkg.sv =====
// Shared types and constants for the march word verifier.
package mwv_pkg;

	// Fixed field widths
	localparam int unsigned WORD_BITS      = 64;
	localparam int unsigned OFFSET_BITS    = 32;
	localparam int unsigned TOTAL_BITS     = 32;
	localparam int unsigned SAMPLE_BITS    = 16;
	localparam int unsigned CFG_DATA_BITS  = 32;
	localparam int unsigned CFG_INDEX_BITS = 8;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_COUNT   = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MARCH_MODE   = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DESCENDING   = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_LIMIT = 8'd3;

	// Reset values of the configuration registers
	localparam logic [31:0]            WORD_COUNT_RST   = 32'd1024;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_LIMIT_RST = 16'd16;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [31:0]            word_count;
		logic                   march_mode;
		logic                   descending;
		logic [SAMPLE_BITS-1:0] sample_limit;
	} cfg_t;

	// Per-word status from the pass counters
	typedef struct packed {
		logic [OFFSET_BITS-1:0] word_offset;
		logic                   sample_logged;
		logic [TOTAL_BITS-1:0]  error_total;
		logic                   pass_last;
	} pass_status_t;

endpackage

// ===== src/march_word_verifier.sv =====
// Top level of the march word verifier: input stage, compare and result register.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid/in_ready, observed_word, expected_word | in
//  result  | out_valid/out_ready, word_offset .. pass_last | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data     | in
//
// One word per cycle while the result is not stalled; each word passes the input register,
// then the result register, which is loaded with the compare and counter update.
// Reset clears the counters and the valid flags; configuration returns to its defaults.
// A stalled result holds the result register and, once the input register is full,
// drops in_ready; a config write is taken in any cycle and acts on the next word.
module march_word_verifier #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mwv_pkg::WORD_BITS-1:0]        observed_word,
	input  logic [mwv_pkg::WORD_BITS-1:0]        expected_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mwv_pkg::OFFSET_BITS-1:0]      word_offset,
	output logic                                 mismatch,
	output logic                                 sample_logged,
	output logic [mwv_pkg::WORD_BITS-1:0]        failing_word,
	output logic                                 write_enable,
	output logic [mwv_pkg::WORD_BITS-1:0]        write_data,
	output logic [mwv_pkg::TOTAL_BITS-1:0]       error_total,
	output logic                                 pass_last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mwv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mwv_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	mwv_pkg::cfg_t                cfg;
	mwv_pkg::pass_status_t        status;

	logic                         valid_s1;
	logic [mwv_pkg::WORD_BITS-1:0] obs_s1;
	logic [mwv_pkg::WORD_BITS-1:0] exp_s1;
	logic                         valid_s2;
	logic                         miss_s1;
	logic                         advance;
	logic                         step;

	mwv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Result register free or being emptied this cycle
	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign miss_s1  = (obs_s1 != exp_s1);

	mwv_pass_ctrl #(
		.COUNT_BITS (COUNT_BITS)
	) u_pass (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.miss   (miss_s1),
		.cfg    (cfg),
		.status (status)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			obs_s1 <= observed_word;
			exp_s1 <= expected_word;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			word_offset   <= status.word_offset;
			mismatch      <= miss_s1;
			sample_logged <= status.sample_logged;
			failing_word  <= obs_s1;
			write_enable  <= cfg.march_mode;
			write_data    <= cfg.march_mode ? ~exp_s1 : '0;
			error_total   <= status.error_total;
			pass_last     <= status.pass_last;
		end
	end

	assign out_valid = valid_s2;

endmodule

// ===== src/mwv_cfg_regs.sv =====
// Configuration register file of the march word verifier.
module mwv_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mwv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mwv_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output mwv_pkg::cfg_t                        cfg
);

	mwv_pkg::cfg_t cfg_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.word_count   <= mwv_pkg::WORD_COUNT_RST;
			cfg_q.march_mode   <= 1'b0;
			cfg_q.descending   <= 1'b0;
			cfg_q.sample_limit <= mwv_pkg::SAMPLE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mwv_pkg::CFG_WORD_COUNT: begin
					cfg_q.word_count <= cfg_data[31:0];
				end
				mwv_pkg::CFG_MARCH_MODE: begin
					cfg_q.march_mode <= cfg_data[0];
				end
				mwv_pkg::CFG_DESCENDING: begin
					cfg_q.descending <= cfg_data[0];
				end
				mwv_pkg::CFG_SAMPLE_LIMIT: begin
					cfg_q.sample_limit <= cfg_data[mwv_pkg::SAMPLE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/mwv_pass_ctrl.sv =====
// Pass counters: position, error count and sample count, with offset and end-of-pass.
module mwv_pass_ctrl #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  miss,
	input  mwv_pkg::cfg_t         cfg,
	output mwv_pkg::pass_status_t status
);

	// Compare width: wide enough for position+1 and a 32-bit count
	localparam int unsigned EXT_BITS = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

	logic [COUNT_BITS-1:0]           position_q;
	logic [COUNT_BITS-1:0]           errors_q;
	logic [mwv_pkg::SAMPLE_BITS-1:0] samples_q;

	logic [EXT_BITS-1:0]             count_ext;
	logic [EXT_BITS-1:0]             pos_ext;
	logic [EXT_BITS-1:0]             pos_inc;
	logic [EXT_BITS-1:0]             desc_off;
	logic [EXT_BITS-1:0]             err_ext;
	logic [COUNT_BITS-1:0]           errors_nx;
	logic                            err_full;
	logic                            take_sample;
	logic                            last;

	// A zero count behaves as a count of one
	always_comb begin
		count_ext = EXT_BITS'(cfg.word_count);
		if (cfg.word_count == '0) begin
			count_ext = EXT_BITS'(1);
		end
	end

	assign pos_ext  = EXT_BITS'(position_q);
	assign pos_inc  = pos_ext + EXT_BITS'(1);
	assign desc_off = count_ext - EXT_BITS'(1) - pos_ext;
	assign last     = (pos_inc >= count_ext);

	// Saturating error count, sample flag while under the limit
	assign err_full    = (errors_q == {COUNT_BITS{1'b1}});
	assign errors_nx   = (miss && !err_full) ? errors_q + COUNT_BITS'(1) : errors_q;
	assign err_ext     = EXT_BITS'(errors_nx);
	assign take_sample = miss && (samples_q < cfg.sample_limit);

	always_comb begin
		status.word_offset   = cfg.descending ? desc_off[mwv_pkg::OFFSET_BITS-1:0]
		                                      : pos_ext[mwv_pkg::OFFSET_BITS-1:0];
		status.sample_logged = take_sample;
		status.error_total   = err_ext[mwv_pkg::TOTAL_BITS-1:0];
		status.pass_last     = last;
	end

	// Counters advance on each word; all restart after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			errors_q   <= '0;
			samples_q  <= '0;
		end else if (step) begin
			if (last) begin
				position_q <= '0;
				errors_q   <= '0;
				samples_q  <= '0;
			end else begin
				position_q <= position_q + COUNT_BITS'(1);
				errors_q   <= errors_nx;
				if (take_sample) begin
					samples_q <= samples_q + mwv_pkg::SAMPLE_BITS'(1);
				end
			end
		end
	end

endmodule

// ===== src/mwv_checker.sv =====
// Port-level checks for the march word verifier, bound to the top level.
module mwv_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [mwv_pkg::OFFSET_BITS-1:0]      word_offset,
	input logic                                 mismatch,
	input logic                                 sample_logged,
	input logic                                 write_enable,
	input logic [mwv_pkg::WORD_BITS-1:0]        write_data,
	input logic [mwv_pkg::TOTAL_BITS-1:0]       error_total
);

	// A stalled result keeps its offset
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_offset))
		else $error("result changed while stalled");

	// Only a mismatch can be flagged for the log
	a_logged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_logged |-> mismatch)
		else $error("sample flagged without mismatch");

	// No write data without a write request
	a_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> write_data == '0)
		else $error("write data set with write disabled");

	// A mismatch always shows in the running total
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mismatch |-> error_total != '0)
		else $error("mismatch with zero error total");

endmodule

bind march_word_verifier mwv_checker u_mwv_checker (.*);
